### rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TOTAL_BLOCKS_DEF = 4096;
    localparam int GROUP_SIZE_DEF   = 1024;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SEL_W = 5;

    localparam int OPERATION_W     = 2;
    localparam int BLOCK_ID_W      = 12;
    localparam int BLOCKS_IN_USE_W = 13;
    localparam int TOTAL_FREE_W    = 13;
    localparam int GROUP_FREE_W    = 11;

    localparam logic [BLOCKS_IN_USE_W-1:0] BLOCKS_IN_USE_RST = 13'd4096;

    typedef enum logic [OPERATION_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_QUERY = 2'd1,
        OP_MARK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_QUERY,
        MODE_TAKE,
        MODE_MISS,
        MODE_OUTSIDE
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_APPLY,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic scan_step;
        logic fetch;
        logic apply;
        logic deliver;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic req_alloc;
        logic scan_found;
        logic scan_miss;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/bba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: one beat carries an operation and a block number.
// ----------------------------------------------------------------------------
interface bba_req_if;
    import bba_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPERATION_W-1:0] operation;
    logic [BLOCK_ID_W-1:0]  block_id;

    modport source (output valid, output operation, output block_id, input ready);
    modport sink   (input valid, input operation, input block_id, output ready);
endinterface

### rtl/bba_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_res_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
interface bba_res_if;
    import bba_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BLOCK_ID_W-1:0]   result_block;
    logic                    hit;
    logic [TOTAL_FREE_W-1:0] total_free;
    logic [GROUP_FREE_W-1:0] group_free;

    modport source (output valid, output result_block, output hit, output total_free,
                    output group_free, input ready);
    modport sink   (input valid, input result_block, input hit, input total_free,
                    input group_free, output ready);
endinterface

### rtl/bba_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cfg_if
// Configuration write channel for the blocks_in_use register.
// ----------------------------------------------------------------------------
interface bba_cfg_if;
    import bba_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [BLOCKS_IN_USE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, request accept, scan, fetch, update, deliver.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output bba_pkg::ctrl_cmd_t  cmd,
    input  bba_pkg::dp_status_t st
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.req_alloc ? ST_SCAN : ST_FETCH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_found || st.scan_miss)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (st.out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !(st.scan_found && st.scan_miss))
        else $error("scan reports found and miss together");

    a_accept_leads_to_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_SCAN || state_reg == ST_FETCH)
        else $error("accepted beat did not start scan or fetch");
`endif

endmodule

### rtl/bba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap and group counter memories, free counter, scan logic and result
// registers.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int TOTAL_BLOCKS = bba_pkg::TOTAL_BLOCKS_DEF,
    parameter int GROUP_SIZE   = bba_pkg::GROUP_SIZE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bba_pkg::ctrl_cmd_t                   cmd,
    output bba_pkg::dp_status_t                  st,
    input  logic [bba_pkg::OPERATION_W-1:0]      in_operation,
    input  logic [bba_pkg::BLOCK_ID_W-1:0]       in_block_id,
    input  logic                                 cfg_valid,
    input  logic [bba_pkg::BLOCKS_IN_USE_W-1:0]  cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bba_pkg::BLOCK_ID_W-1:0]       out_result_block,
    output logic                                 out_hit,
    output logic [bba_pkg::TOTAL_FREE_W-1:0]     out_total_free,
    output logic [bba_pkg::GROUP_FREE_W-1:0]     out_group_free
);
    import bba_pkg::*;

    localparam int WORD_COUNT  = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int GROUP_COUNT = (TOTAL_BLOCKS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int LAST_GROUP  = TOTAL_BLOCKS - (GROUP_COUNT - 1) * GROUP_SIZE;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int GROUP_AW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int BLK_W       = WORD_AW + WORD_SEL_W;
    localparam int SW          = BLK_W + 1;
    localparam int LIM_W       = $clog2(TOTAL_BLOCKS + 1);
    localparam int GC_W        = $clog2(GROUP_SIZE + 1);
    localparam int CW          = (BLOCKS_IN_USE_W > SW) ? BLOCKS_IN_USE_W : SW;
    localparam int XW          = (BLOCK_ID_W > SW) ? BLOCK_ID_W : SW;
    // group index by reciprocal multiply, exact for every BLK_W-bit block number
    localparam int GQ_SHIFT    = BLK_W + $clog2(GROUP_SIZE);
    localparam int PW          = GQ_SHIFT + GROUP_AW;
    localparam longint unsigned GQ_MUL =
        ((64'd1 << GQ_SHIFT) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE);

    // configuration and request registers
    logic [BLOCKS_IN_USE_W-1:0] biu_reg;
    logic [LIM_W-1:0]           lim_reg;
    mode_t                      mode_reg;
    logic [BLK_W-1:0]           tgt_reg;
    logic [BLOCK_ID_W-1:0]      res_block_reg;

    // scan pipeline
    logic [WORD_AW:0]   scan_addr_reg;
    logic [WORD_AW-1:0] chk_addr_reg;
    logic               chk_valid_reg;

    // clearing pass and counters
    logic [WORD_AW-1:0] clr_addr_reg;
    logic [LIM_W-1:0]   total_free_reg;
    logic               res_hit_reg;
    logic [GC_W-1:0]    res_gfree_reg;

    // output register
    logic                    out_valid_reg;
    logic [BLOCK_ID_W-1:0]   out_block_reg;
    logic                    out_hit_reg;
    logic [TOTAL_FREE_W-1:0] out_total_reg;
    logic [GROUP_FREE_W-1:0] out_group_reg;

    // memory ports
    logic                 w_we;
    logic [WORD_AW-1:0]   w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_AW-1:0]   w_raddr;
    logic [WORD_BITS-1:0] w_rdata;
    logic                 g_we;
    logic [GROUP_AW-1:0]  g_waddr;
    logic [GC_W-1:0]      g_wdata;
    logic [GROUP_AW-1:0]  g_raddr;
    logic [GC_W-1:0]      g_rdata;

    logic [LIM_W-1:0]      lim_calc;
    logic                  in_outside;
    logic [WORD_AW-1:0]    tgt_word;
    logic [WORD_SEL_W-1:0] tgt_bit;
    logic [WORD_BITS-1:0]  tgt_onehot;
    logic [PW-1:0]         grp_prod;
    logic                  issue_ok;
    logic [SW-1:0]         chk_base;
    logic [SW-1:0]         chk_remain;
    logic [WORD_BITS-1:0]  chk_mask;
    logic [WORD_BITS-1:0]  chk_free;
    logic [WORD_BITS-1:0]  chk_lowest;
    logic [WORD_SEL_W-1:0] chk_pos;
    logic                  clr_grp_ok;
    logic [GC_W-1:0]       clr_grp_init;
    logic                  take;
    logic [GC_W-1:0]       g_dec;
    logic [LIM_W-1:0]      total_dec;
    logic                  apply_hit;
    logic [GC_W-1:0]       apply_gfree;

    assign lim_calc   = (CW'(biu_reg) < CW'(TOTAL_BLOCKS)) ? LIM_W'(biu_reg)
                                                           : LIM_W'(TOTAL_BLOCKS);
    assign in_outside = XW'(in_block_id) >= XW'(TOTAL_BLOCKS);

    assign tgt_word   = tgt_reg[BLK_W-1:WORD_SEL_W];
    assign tgt_bit    = tgt_reg[WORD_SEL_W-1:0];
    assign tgt_onehot = WORD_BITS'(1) << tgt_bit;
    assign grp_prod   = PW'(tgt_reg) * PW'(GQ_MUL);

    // scan: issue one word read per beat, check the word read in the beat before
    assign issue_ok   = {scan_addr_reg, {WORD_SEL_W{1'b0}}} < SW'(lim_reg);
    assign chk_base   = {1'b0, chk_addr_reg, {WORD_SEL_W{1'b0}}};
    assign chk_remain = SW'(lim_reg) - chk_base;
    assign chk_mask   = (chk_remain >= SW'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                        : ~({WORD_BITS{1'b1}} << chk_remain[WORD_SEL_W-1:0]);
    assign chk_free   = ~w_rdata & chk_mask;
    assign chk_lowest = chk_free & (~chk_free + WORD_BITS'(1));

    always_comb
    begin
        chk_pos = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (chk_lowest[j])
            begin
                chk_pos = chk_pos | WORD_SEL_W'(j);
            end
        end
    end

    assign clr_grp_ok   = {1'b0, clr_addr_reg} < (WORD_AW + 1)'(GROUP_COUNT);
    assign clr_grp_init = ({1'b0, clr_addr_reg} == (WORD_AW + 1)'(GROUP_COUNT - 1))
                          ? GC_W'(LAST_GROUP) : GC_W'(GROUP_SIZE);

    assign take      = (mode_reg == MODE_TAKE);
    assign g_dec     = (g_rdata != '0) ? g_rdata - GC_W'(1) : g_rdata;
    assign total_dec = (total_free_reg != '0) ? total_free_reg - LIM_W'(1) : total_free_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_QUERY:
            begin
                apply_hit   = w_rdata[tgt_bit];
                apply_gfree = g_rdata;
            end
            MODE_TAKE:
            begin
                apply_hit   = 1'b1;
                apply_gfree = g_dec;
            end
            MODE_MISS:
            begin
                apply_hit   = 1'b0;
                apply_gfree = g_rdata;
            end
            default:
            begin
                apply_hit   = 1'b0;
                apply_gfree = '0;
            end
        endcase
    end

    // memory port selection
    assign w_raddr = cmd.scan_step ? scan_addr_reg[WORD_AW-1:0] : tgt_word;
    assign w_we    = cmd.clear_step | (cmd.apply & take);
    assign w_waddr = cmd.clear_step ? clr_addr_reg : tgt_word;
    assign w_wdata = cmd.clear_step ? '0 : (w_rdata | tgt_onehot);

    assign g_raddr = grp_prod[PW-1 -: GROUP_AW];
    assign g_we    = (cmd.clear_step & clr_grp_ok) | (cmd.apply & take);
    assign g_waddr = cmd.clear_step ? GROUP_AW'(clr_addr_reg) : g_raddr;
    assign g_wdata = cmd.clear_step ? clr_grp_init : g_dec;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT),
        .AW    (WORD_AW)
    ) u_word_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    bba_ram #(
        .WIDTH (GC_W),
        .DEPTH (GROUP_COUNT),
        .AW    (GROUP_AW)
    ) u_group_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            biu_reg        <= BLOCKS_IN_USE_RST;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            chk_valid_reg  <= 1'b0;
            total_free_reg <= LIM_W'(TOTAL_BLOCKS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                biu_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + WORD_AW'(1);
            end
            if (cmd.accept)
            begin
                scan_addr_reg <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                chk_valid_reg <= issue_ok;
                if (issue_ok)
                begin
                    scan_addr_reg <= scan_addr_reg + (WORD_AW + 1)'(1);
                end
            end
            if (cmd.apply && take)
            begin
                total_free_reg <= total_dec;
            end
            if (cmd.deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            chk_addr_reg <= scan_addr_reg[WORD_AW-1:0];
        end
        if (cmd.accept)
        begin
            lim_reg       <= lim_calc;
            res_block_reg <= in_block_id;
            tgt_reg       <= BLK_W'(in_block_id);
            if (in_operation == OP_ALLOC)
            begin
                mode_reg <= MODE_QUERY;
            end
            else if (in_outside)
            begin
                mode_reg <= MODE_OUTSIDE;
            end
            else if (in_operation == OP_MARK)
            begin
                mode_reg <= MODE_TAKE;
            end
            else
            begin
                mode_reg <= MODE_QUERY;
            end
        end
        else if (cmd.scan_step && st.scan_found)
        begin
            tgt_reg       <= {chk_addr_reg, chk_pos};
            res_block_reg <= BLOCK_ID_W'({chk_addr_reg, chk_pos});
            mode_reg      <= MODE_TAKE;
        end
        else if (cmd.scan_step && st.scan_miss)
        begin
            tgt_reg       <= '0;
            res_block_reg <= '0;
            mode_reg      <= MODE_MISS;
        end
        if (cmd.apply)
        begin
            res_hit_reg   <= apply_hit;
            res_gfree_reg <= apply_gfree;
        end
        if (cmd.deliver)
        begin
            out_block_reg <= res_block_reg;
            out_hit_reg   <= res_hit_reg;
            out_total_reg <= TOTAL_FREE_W'(total_free_reg);
            out_group_reg <= GROUP_FREE_W'(res_gfree_reg);
        end
    end

    assign st.clear_last = (clr_addr_reg == WORD_AW'(WORD_COUNT - 1));
    assign st.req_alloc  = (in_operation == OP_ALLOC);
    assign st.scan_found = chk_valid_reg && (chk_free != '0);
    assign st.scan_miss  = !chk_valid_reg && !issue_ok;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_result_block = out_block_reg;
    assign out_hit          = out_hit_reg;
    assign out_total_free   = out_total_reg;
    assign out_group_free   = out_group_reg;

`ifndef ASSERT_OFF
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_free_reg <= LIM_W'(TOTAL_BLOCKS))
        else $error("total free count above block count");

    a_take_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && take |=> (total_free_reg + LIM_W'(1) == $past(total_free_reg))
                              || ($past(total_free_reg) == '0))
        else $error("take did not decrement total free count");

    a_check_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step && chk_valid_reg |-> chk_base < SW'(lim_reg))
        else $error("scan checked a word beyond the search limit");
`endif

endmodule

### rtl/block_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit allocator over a block occupancy bitmap with group and total free
// counters.
//
// req carries one request per beat: allocate lowest free block below
// blocks_in_use, query a block, or mark a block occupied. res returns exactly
// one beat per request with the block, hit flag and the free counts after it.
// cfg writes blocks_in_use; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. Reset starts a clearing
// pass over the bitmap memory and the group counters; req is not ready until
// done. Query and mark pass from accept through the fetch, apply and deliver
// states to the output register. Allocate scans the bitmap memory one 32-bit
// word per cycle through its single read port, up to min(blocks_in_use,
// TOTAL_BLOCKS) blocks; a hit in a word ends the scan at that word.
// A finished result sits in the output register while res is stalled; the
// next request is accepted meanwhile and waits only if its own result is
// ready before the previous one is taken.
// ----------------------------------------------------------------------------
module block_bitmap_allocator #(
    parameter int TOTAL_BLOCKS = bba_pkg::TOTAL_BLOCKS_DEF,
    parameter int GROUP_SIZE   = bba_pkg::GROUP_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bba_req_if.sink    req,
    bba_res_if.source  res,
    bba_cfg_if.sink    cfg
);
    import bba_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    bba_datapath #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS),
        .GROUP_SIZE   (GROUP_SIZE)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .in_operation     (req.operation),
        .in_block_id      (req.block_id),
        .cfg_valid        (cfg.valid),
        .cfg_data         (cfg.data),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .out_result_block (res.result_block),
        .out_hit          (res.hit),
        .out_total_free   (res.total_free),
        .out_group_free   (res.group_free)
    );

endmodule
